@@ sv/mmb_pkg.sv @@
// Shared types, constants and helper functions of the model matrix builder.
package mmb_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;
    localparam int ATAN_LEN      = 24;
    localparam int NSTG          = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    localparam int CW = 34;              // CORDIC datapath, Q2.30 plus guard bits
    localparam int TW = FRAC_BITS + 2;   // sine / cosine, range [-1, 1]
    localparam int RW = FRAC_BITS + 3;   // rotation entry, range [-2, 2]
    localparam int PW = RW + 32;         // rotation entry times a 32-bit value
    localparam int EW = PW + 3;          // column entry before saturation

    localparam logic signed [CW-1:0] GAIN_Q30 = CW'(64'sd652032874);
    localparam logic [31:0]          PI_Q30   = 32'd3373259426;
    localparam logic signed [EW-1:0] HALF_E   = EW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [EW-1:0] MAX_E    = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0] MIN_E    = EW'(-64'sd2147483648);
    localparam logic [31:0]          ONE_Q    = 32'(64'd1 << FRAC_BITS);

    typedef enum logic [1:0] {
        TRIG_CORDIC = 2'd0,
        TRIG_ZERO   = 2'd1,
        TRIG_POS    = 2'd2,
        TRIG_NEG    = 2'd3
    } trig_kind_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        trig_kind_t           kind;
        logic                 flip;
    } cordic_lane_t;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] scale;
        logic [2:0][31:0] pivot;
    } geom_t;

    typedef struct packed {
        logic [2:0][31:0] elem;
        logic             sat;
    } col_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return $signed({{(CW-32){1'b0}}, v});
    endfunction

    // Round to nearest, ties toward plus infinity, dropping FRAC_BITS bits.
    function automatic logic signed [EW-1:0] rnd(input logic signed [EW-1:0] v);
        return (v + HALF_E) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [TW-1:0] fmul_t(input logic signed [TW-1:0] a,
                                                     input logic signed [TW-1:0] b);
        logic signed [EW-1:0] p;
        p = EW'(a) * EW'(b);
        return TW'(rnd(p));
    endfunction

endpackage

@@ sv/mmb_prep.sv @@
// Angle fold, special-angle detection and radian conversion ahead of the CORDIC chain.
module mmb_prep (
    input  logic                  clk,
    input  logic                  en,
    input  logic [15:0]           angle,
    output mmb_pkg::cordic_lane_t q
);

    mmb_pkg::cordic_lane_t q_reg;
    mmb_pkg::cordic_lane_t q_next;
    logic signed [16:0]    a;
    logic [14:0]           mag;
    logic [46:0]           prod;
    logic [31:0]           zmag;

    always_comb
    begin
        a = 17'($signed(angle));
        q_next.flip = 1'b0;
        if (a > 17'sd16384)
        begin
            a = a - 17'sd32768;
            q_next.flip = 1'b1;
        end
        else if (a < -17'sd16384)
        begin
            a = a + 17'sd32768;
            q_next.flip = 1'b1;
        end
        if (a == 17'sd0)
            q_next.kind = mmb_pkg::TRIG_ZERO;
        else if (a == 17'sd16384)
            q_next.kind = mmb_pkg::TRIG_POS;
        else if (a == -17'sd16384)
            q_next.kind = mmb_pkg::TRIG_NEG;
        else
            q_next.kind = mmb_pkg::TRIG_CORDIC;
        mag  = a[16] ? 15'(-a) : a[14:0];
        prod = 47'(mag) * 47'(mmb_pkg::PI_Q30);
        zmag = 32'((prod + 47'd16384) >> 15);
        q_next.z = a[16] ? -$signed({{(mmb_pkg::CW-32){1'b0}}, zmag})
                         :  $signed({{(mmb_pkg::CW-32){1'b0}}, zmag});
        q_next.x = mmb_pkg::GAIN_Q30;
        q_next.y = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ sv/mmb_cordic_cell.sv @@
// One CORDIC micro-rotation cell; cells are chained, one per iteration.
module mmb_cordic_cell (
    input  logic                  clk,
    input  logic                  en,
    input  logic [4:0]            stage,
    input  mmb_pkg::cordic_lane_t d,
    output mmb_pkg::cordic_lane_t q
);

    mmb_pkg::cordic_lane_t q_reg;
    mmb_pkg::cordic_lane_t q_next;
    logic signed [mmb_pkg::CW-1:0] xs;
    logic signed [mmb_pkg::CW-1:0] ys;

    always_comb
    begin
        xs = d.x >>> stage;
        ys = d.y >>> stage;
        q_next = d;
        if (!d.z[mmb_pkg::CW-1])
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - mmb_pkg::atan_q30(stage);
        end
        else
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + mmb_pkg::atan_q30(stage);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ sv/mmb_matrix.sv @@
// Five-stage matrix datapath: trig rounding, rotation products, entries, scaling, columns.
module mmb_matrix (
    input  logic                  clk,
    input  logic                  en,
    input  mmb_pkg::cordic_lane_t lane_x,
    input  mmb_pkg::cordic_lane_t lane_y,
    input  mmb_pkg::cordic_lane_t lane_z,
    input  mmb_pkg::geom_t        geom,
    output mmb_pkg::col_t [3:0]   cols
);

    localparam int TW = mmb_pkg::TW;
    localparam int RW = mmb_pkg::RW;
    localparam int PW = mmb_pkg::PW;
    localparam int EW = mmb_pkg::EW;
    localparam int CW = mmb_pkg::CW;
    localparam int SH = 30 - mmb_pkg::FRAC_BITS;
    localparam logic signed [CW-1:0] HALF_C = CW'(64'sd1 <<< (SH - 1));
    localparam logic signed [CW-1:0] ONE_C  = CW'(64'sd1 <<< mmb_pkg::FRAC_BITS);
    localparam logic signed [TW-1:0] ONE_T  = TW'(64'sd1 <<< mmb_pkg::FRAC_BITS);

    mmb_pkg::cordic_lane_t lanes [3];
    logic signed [TW-1:0]  c_next [3];
    logic signed [TW-1:0]  s_next [3];
    logic signed [CW-1:0]  xr;
    logic signed [CW-1:0]  yr;
    logic signed [TW-1:0]  cv;
    logic signed [TW-1:0]  sv;

    // stage 0
    logic signed [TW-1:0]  c_reg [3];
    logic signed [TW-1:0]  s_reg [3];
    mmb_pkg::geom_t        g0_reg;
    // stage 1
    logic signed [TW-1:0]  sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, cxcz_reg;
    logic signed [TW-1:0]  cxsz_reg, sxsz_reg, sxcz_reg, sxcy_reg, cxcy_reg;
    logic signed [TW-1:0]  sy1_reg, cz1_reg, sz1_reg;
    mmb_pkg::geom_t        g1_reg;
    // stage 2
    logic signed [RW-1:0]  r_reg [3][3];
    logic signed [RW-1:0]  r_next [3][3];
    mmb_pkg::geom_t        g2_reg;
    // stage 3
    logic signed [PW-1:0]  ps_reg [3][3];
    logic signed [PW-1:0]  pp_reg [3][3];
    mmb_pkg::geom_t        g3_reg;
    // stage 4
    mmb_pkg::col_t [3:0]   cols_reg;
    mmb_pkg::col_t [3:0]   cols_next;

    assign lanes[0] = lane_x;
    assign lanes[1] = lane_y;
    assign lanes[2] = lane_z;

    always_comb
    begin
        xr = '0;
        yr = '0;
        cv = '0;
        sv = '0;
        for (int l = 0; l < 3; l++)
        begin
            xr = (lanes[l].x + HALF_C) >>> SH;
            yr = (lanes[l].y + HALF_C) >>> SH;
            case (lanes[l].kind)
                mmb_pkg::TRIG_ZERO:
                begin
                    cv = ONE_T;
                    sv = '0;
                end
                mmb_pkg::TRIG_POS:
                begin
                    cv = '0;
                    sv = ONE_T;
                end
                mmb_pkg::TRIG_NEG:
                begin
                    cv = '0;
                    sv = -ONE_T;
                end
                default:
                begin
                    cv = (xr > ONE_C) ? ONE_T : (xr < -ONE_C) ? -ONE_T : TW'(xr);
                    sv = (yr > ONE_C) ? ONE_T : (yr < -ONE_C) ? -ONE_T : TW'(yr);
                end
            endcase
            c_next[l] = lanes[l].flip ? -cv : cv;
            s_next[l] = lanes[l].flip ? -sv : sv;
        end
    end

    always_comb
    begin
        r_next[0][0] = RW'(cycz_reg);
        r_next[0][1] = -RW'(cysz_reg);
        r_next[0][2] = RW'(sy1_reg);
        r_next[1][0] = RW'(mmb_pkg::fmul_t(sxsy_reg, cz1_reg)) + RW'(cxsz_reg);
        r_next[1][1] = RW'(cxcz_reg) - RW'(mmb_pkg::fmul_t(sxsy_reg, sz1_reg));
        r_next[1][2] = -RW'(sxcy_reg);
        r_next[2][0] = RW'(sxsz_reg) - RW'(mmb_pkg::fmul_t(cxsy_reg, cz1_reg));
        r_next[2][1] = RW'(mmb_pkg::fmul_t(cxsy_reg, sz1_reg)) + RW'(sxcz_reg);
        r_next[2][2] = RW'(cxcy_reg);
    end

    always_comb
    begin
        logic signed [EW-1:0] e;
        logic signed [EW-1:0] acc;
        e   = '0;
        acc = '0;
        for (int j = 0; j < 4; j++)
        begin
            cols_next[j].sat = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                if (j < 3)
                    e = mmb_pkg::rnd(EW'(ps_reg[k][j]));
                else
                begin
                    acc = EW'(pp_reg[k][0]) + EW'(pp_reg[k][1]) + EW'(pp_reg[k][2]);
                    e = EW'($signed(g3_reg.pos[k])) + EW'($signed(g3_reg.pivot[k]))
                        - mmb_pkg::rnd(acc);
                end
                if (e > mmb_pkg::MAX_E)
                begin
                    cols_next[j].elem[k] = 32'h7FFF_FFFF;
                    cols_next[j].sat = 1'b1;
                end
                else if (e < mmb_pkg::MIN_E)
                begin
                    cols_next[j].elem[k] = 32'h8000_0000;
                    cols_next[j].sat = 1'b1;
                end
                else
                    cols_next[j].elem[k] = e[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                c_reg[l] <= c_next[l];
                s_reg[l] <= s_next[l];
            end
            g0_reg <= geom;

            sxsy_reg <= mmb_pkg::fmul_t(s_reg[0], s_reg[1]);
            cxsy_reg <= mmb_pkg::fmul_t(c_reg[0], s_reg[1]);
            cycz_reg <= mmb_pkg::fmul_t(c_reg[1], c_reg[2]);
            cysz_reg <= mmb_pkg::fmul_t(c_reg[1], s_reg[2]);
            cxcz_reg <= mmb_pkg::fmul_t(c_reg[0], c_reg[2]);
            cxsz_reg <= mmb_pkg::fmul_t(c_reg[0], s_reg[2]);
            sxsz_reg <= mmb_pkg::fmul_t(s_reg[0], s_reg[2]);
            sxcz_reg <= mmb_pkg::fmul_t(s_reg[0], c_reg[2]);
            sxcy_reg <= mmb_pkg::fmul_t(s_reg[0], c_reg[1]);
            cxcy_reg <= mmb_pkg::fmul_t(c_reg[0], c_reg[1]);
            sy1_reg  <= s_reg[1];
            cz1_reg  <= c_reg[2];
            sz1_reg  <= s_reg[2];
            g1_reg   <= g0_reg;

            r_reg  <= r_next;
            g2_reg <= g1_reg;

            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    ps_reg[k][j] <= PW'(r_reg[k][j]) * PW'($signed(g2_reg.scale[j]));
                    pp_reg[k][j] <= PW'(r_reg[k][j]) * PW'($signed(g2_reg.pivot[j]));
                end
            end
            g3_reg <= g2_reg;

            cols_reg <= cols_next;
        end
    end

    assign cols = cols_reg;

endmodule

@@ sv/mmb_colout.sv @@
// Output buffer that holds one finished matrix and sends it out one column per transaction.
module mmb_colout (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                d_valid,
    input  mmb_pkg::col_t [3:0] d,
    output logic                load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [135:0]        m_tdata,
    output logic [0:0]          m_tuser,
    output logic                m_tlast
);

    logic                busy_reg;
    logic                busy_next;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    mmb_pkg::col_t [3:0] cols_reg;
    mmb_pkg::col_t       cur;
    logic                done;

    assign done = busy_reg && m_tready && (cnt_reg == 2'd3);
    assign load = d_valid && (!busy_reg || done);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end
        else if (busy_reg && m_tready)
        begin
            if (cnt_reg == 2'd3)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cols_reg <= d;
    end

    assign cur      = cols_reg[cnt_reg];
    assign m_tvalid = busy_reg;
    assign m_tlast  = (cnt_reg == 2'd3);
    assign m_tuser  = cur.sat;
    assign m_tdata  = {6'd0,
                       (cnt_reg == 2'd3) ? mmb_pkg::ONE_Q : 32'd0,
                       cur.elem[2], cur.elem[1], cur.elem[0], cnt_reg};

endmodule

@@ sv/model_matrix_builder_unit.sv @@
// Top level of the model matrix builder: CORDIC cell chain, matrix datapath, column output.
// m_tvalid rises once an input transaction has passed the prep register, the CORDIC cells,
// the matrix datapath stages and the column output buffer register;
// the other three columns follow one per cycle when m_tready is high.
// Each item leaves as four column transactions through the single column output port;
// the cell chain and datapath take a new item every cycle while the output has room.
// Reset clears the stage valid bits and the output buffer state; data registers are not reset.
module model_matrix_builder_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z,
    // pivot_x, pivot_y, pivot_z
    input  logic [335:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // column_index, elem_row0, elem_row1, elem_row2, elem_row3, zero pad
    output logic [135:0] m_tdata,
    // saturated
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam int NC = mmb_pkg::NSTG;
    localparam int L  = NC + 6;

    logic [L-1:0]          vld_reg;
    logic                  en;
    logic                  load;
    mmb_pkg::geom_t        geom_in;
    mmb_pkg::geom_t        geom_reg [NC+1];
    mmb_pkg::cordic_lane_t lane [3][NC+1];
    mmb_pkg::col_t [3:0]   cols;

    assign en       = !vld_reg[L-1] || load;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[L-2:0], s_tvalid};
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geom_in.pos[k]   = s_tdata[32*k +: 32];
            geom_in.scale[k] = s_tdata[96 + 32*k +: 32];
            geom_in.pivot[k] = s_tdata[240 + 32*k +: 32];
        end
    end

    // payload shift line alongside the CORDIC cells
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geom_reg[0] <= geom_in;
            for (int i = 1; i <= NC; i++)
                geom_reg[i] <= geom_reg[i-1];
        end
    end

    genvar l, i;
    generate
        for (l = 0; l < 3; l++)
        begin : g_lane
            mmb_prep u_prep (
                .clk   (clk),
                .en    (en),
                .angle (s_tdata[192 + 16*l +: 16]),
                .q     (lane[l][0])
            );
            for (i = 0; i < NC; i++)
            begin : g_cell
                mmb_cordic_cell u_cell (
                    .clk   (clk),
                    .en    (en),
                    .stage (5'(i)),
                    .d     (lane[l][i]),
                    .q     (lane[l][i+1])
                );
            end
        end
    endgenerate

    mmb_matrix u_matrix (
        .clk    (clk),
        .en     (en),
        .lane_x (lane[0][NC]),
        .lane_y (lane[1][NC]),
        .lane_z (lane[2][NC]),
        .geom   (geom_reg[NC]),
        .cols   (cols)
    );

    mmb_colout u_colout (
        .clk      (clk),
        .rst_n    (rst_n),
        .d_valid  (vld_reg[L-1]),
        .d        (cols),
        .load     (load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
